[rtl/gww_pkg.sv]
// ----------------------------------------------------------------------------
// gww_pkg
// Shared types and constants of the greedy word wrap block: item payloads,
// configuration register indexes and the command and status groups between
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gww_pkg;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;

  localparam int CFG_DATA_W = 12;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MAX_WIDTH     = 2'd0;
  localparam cfg_idx_t CFG_GLYPH_ADVANCE = 2'd1;
  localparam cfg_idx_t CFG_LINE_CAPACITY = 2'd2;

  localparam logic [11:0] MAX_WIDTH_RST     = 12'd320;
  localparam logic [7:0]  GLYPH_ADVANCE_RST = 8'd8;
  localparam logic [6:0]  LINE_CAPACITY_RST = 7'd64;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       line_empty;
    logic       line_end;
  } out_item_t;

  // What the current byte does to the line.
  typedef enum logic [2:0] {
    ACT_DROP,
    ACT_NEWLINE,
    ACT_BREAK,
    ACT_CARRY,
    ACT_STORE,
    ACT_STORE_CAP
  } act_t;

  typedef struct packed {
    logic load_in;
    logic proc;
    logic emit_rd;
    logic emit_ld;
    logic mark_ld;
    logic scan_rd;
    logic scan_ld;
    logic scan_end;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic in_eot;
    logic scanning;
    logic scan_more;
    logic emit_zero;
    logic emit_mark;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/gww_in_if.sv]
// ----------------------------------------------------------------------------
// gww_in_if
// Valid/ready channel that carries one text byte item.
// ----------------------------------------------------------------------------
`default_nettype none

interface gww_in_if;
  import gww_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/gww_out_if.sv]
// ----------------------------------------------------------------------------
// gww_out_if
// Valid/ready channel that carries one character item of a wrapped line.
// ----------------------------------------------------------------------------
`default_nettype none

interface gww_out_if;
  import gww_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/gww_dp.sv]
// ----------------------------------------------------------------------------
// gww_dp
// Datapath of the word wrap block: configuration registers, line memory,
// line bookkeeping, the per-byte decision, the rescan pointers and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_dp #(
  parameter int LINE_BUF = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  gww_pkg::cfg_idx_t                 cfg_index,
  input  logic [gww_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  gww_pkg::in_item_t                 in_data,
  input  gww_pkg::cmd_t                     cmd,
  output gww_pkg::stat_t                    stat,
  input  logic                              out_ready,
  output logic                              out_valid,
  output gww_pkg::out_item_t                out_data
);
  import gww_pkg::*;

  localparam int AW  = $clog2(LINE_BUF);
  localparam int CPW = 10;

  // Configuration.
  logic [11:0] max_width;
  logic [7:0]  glyph_advance;
  logic [6:0]  line_capacity;

  // Line state.
  logic [7:0]    line_mem [LINE_BUF];
  logic [7:0]    rdata;
  logic [AW-1:0] count;
  logic [12:0]   width_sum;
  logic [AW-1:0] last_space_pos;
  logic          space_seen;
  logic          line_start;
  logic          swallow;
  logic [AW-1:0] trim_len;
  logic [AW-1:0] trim_sp;

  // Emit and rescan.
  logic [AW-1:0] emit_len;
  logic [AW-1:0] emit_idx;
  logic          emit_mark;
  logic [AW-1:0] scan_ptr;
  logic [AW-1:0] scan_end;
  logic          scanning;
  logic [7:0]    in_byte;
  logic [7:0]    cur_byte;

  logic           is_sp;
  logic           is_tab;
  logic           is_nl;
  logic [13:0]    width_next;
  logic           brk;
  logic [CPW-1:0] cap_raw;
  logic [CPW-1:0] cap_eff;
  logic           cap_hit;
  act_t           act;
  logic           eot_go;
  logic           do_store;
  logic           do_drop;
  logic           do_clear;
  logic           clr_swallow;
  logic [AW-1:0]  emit_len_next;
  logic           emit_mark_next;
  logic           emit_last;

  assign is_sp  = (cur_byte == CH_SPACE);
  assign is_tab = (cur_byte == CH_TAB);
  assign is_nl  = (cur_byte == CH_NL);

  assign width_next = {1'b0, width_sum} + 14'(glyph_advance);
  assign brk        = (width_next > 14'(max_width)) && (count != '0);

  always_comb begin
    cap_raw = CPW'(line_capacity);
    priority if (cap_raw < CPW'(2)) begin
      cap_eff = CPW'(2);
    end else if (cap_raw > CPW'(LINE_BUF)) begin
      cap_eff = CPW'(LINE_BUF);
    end else begin
      cap_eff = cap_raw;
    end
  end

  // The line goes out once it holds capacity minus one characters.
  assign cap_hit = (CPW'(count) + CPW'(2)) >= cap_eff;

  always_comb begin
    priority if (swallow && (is_sp || is_nl)) begin
      act = ACT_DROP;
    end else if (line_start && (is_sp || is_tab)) begin
      act = ACT_DROP;
    end else if (is_nl) begin
      act = ACT_NEWLINE;
    end else if (brk && !is_sp && space_seen) begin
      act = ACT_CARRY;
    end else if (brk) begin
      act = ACT_BREAK;
    end else if (cap_hit) begin
      act = ACT_STORE_CAP;
    end else begin
      act = ACT_STORE;
    end
  end

  assign eot_go   = cmd.load_in && in_data.end_of_text;
  assign do_store = cmd.proc && ((act == ACT_STORE) || (act == ACT_STORE_CAP));
  assign do_drop  = cmd.proc && (act == ACT_DROP);
  assign do_clear = eot_go || (cmd.proc && ((act == ACT_NEWLINE) || (act == ACT_BREAK) ||
                                            (act == ACT_CARRY) || (act == ACT_STORE_CAP)));
  // A break on a space or a full buffer keeps swallowing blanks on the next line.
  assign clr_swallow = cmd.proc && (((act == ACT_BREAK) && is_sp) || (act == ACT_STORE_CAP));

  always_comb begin
    emit_len_next = trim_len;
    if (!eot_go) begin
      unique case (act)
        ACT_CARRY:     emit_len_next = trim_sp;
        ACT_STORE_CAP: emit_len_next = is_sp ? trim_len : count + AW'(1);
        default:       emit_len_next = trim_len;
      endcase
    end
  end

  assign emit_mark_next = cmd.proc && (act == ACT_NEWLINE);
  assign emit_last      = (emit_idx + AW'(1)) == emit_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width      <= MAX_WIDTH_RST;
      glyph_advance  <= GLYPH_ADVANCE_RST;
      line_capacity  <= LINE_CAPACITY_RST;
      count          <= '0;
      width_sum      <= '0;
      last_space_pos <= '0;
      space_seen     <= 1'b0;
      line_start     <= 1'b1;
      swallow        <= 1'b0;
      trim_len       <= '0;
      trim_sp        <= '0;
      scanning       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_WIDTH:     max_width     <= cfg_data[11:0];
          CFG_GLYPH_ADVANCE: glyph_advance <= cfg_data[7:0];
          CFG_LINE_CAPACITY: line_capacity <= cfg_data[6:0];
          default: ;
        endcase
      end

      if (do_clear) begin
        count          <= '0;
        width_sum      <= '0;
        last_space_pos <= '0;
        space_seen     <= 1'b0;
        line_start     <= 1'b1;
        swallow        <= clr_swallow;
        trim_len       <= '0;
        trim_sp        <= '0;
      end else if (do_store) begin
        count      <= count + AW'(1);
        width_sum  <= width_next[12:0];
        line_start <= 1'b0;
        swallow    <= 1'b0;
        if (is_sp) begin
          last_space_pos <= count;
          space_seen     <= 1'b1;
          trim_sp        <= trim_len;
        end else begin
          trim_len <= count + AW'(1);
        end
      end else if (do_drop) begin
        swallow <= swallow && is_sp;
      end

      if (cmd.proc && (act == ACT_CARRY)) begin
        scanning <= 1'b1;
      end else if (cmd.scan_end) begin
        scanning <= 1'b0;
      end

      if (cmd.emit_ld || cmd.mark_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_store) begin
      line_mem[count] <= cur_byte;
    end
    if (cmd.emit_rd) begin
      rdata <= line_mem[emit_idx];
    end else if (cmd.scan_rd) begin
      rdata <= line_mem[scan_ptr];
    end

    if (cmd.load_in) begin
      in_byte  <= in_data.char_byte;
      cur_byte <= in_data.char_byte;
    end else if (cmd.scan_ld) begin
      cur_byte <= rdata;
    end else if (cmd.scan_end) begin
      cur_byte <= in_byte;
    end

    if (do_clear) begin
      emit_len  <= emit_len_next;
      emit_mark <= emit_mark_next;
      emit_idx  <= '0;
    end else if (cmd.emit_ld) begin
      emit_idx <= emit_idx + AW'(1);
    end

    // The word after the last space is read back from the old line.
    if (cmd.proc && (act == ACT_CARRY)) begin
      scan_ptr <= last_space_pos + AW'(1);
      scan_end <= count;
    end else if (cmd.scan_rd) begin
      scan_ptr <= scan_ptr + AW'(1);
    end

    if (cmd.emit_ld) begin
      out_data <= '{out_char: rdata, line_empty: 1'b0, line_end: emit_last};
    end else if (cmd.mark_ld) begin
      out_data <= '{out_char: 8'd0, line_empty: 1'b1, line_end: 1'b1};
    end
  end

  always_comb begin
    stat           = '0;
    stat.act       = act;
    stat.in_eot    = in_data.end_of_text;
    stat.scanning  = scanning;
    stat.scan_more = scan_ptr < scan_end;
    stat.emit_zero = (emit_len == '0);
    stat.emit_mark = emit_mark;
    stat.emit_last = emit_last;
    stat.out_free  = !out_valid || out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, count} <= (AW+1)'(LINE_BUF - 2))
    else $error("line count passed the buffer limit");

  a_trim_bound: assert property (@(posedge clk) disable iff (rst)
    trim_len <= count)
    else $error("trimmed length longer than the line");

  a_carry_scan: assert property (@(posedge clk) disable iff (rst)
    (cmd.proc && (act == ACT_CARRY)) |=> (scanning && (scan_ptr <= scan_end) &&
                                          (count == '0)))
    else $error("carry did not start a rescan on an empty line");

endmodule

`default_nettype wire

[rtl/gww_ctrl.sv]
// ----------------------------------------------------------------------------
// gww_ctrl
// Controller of the word wrap block: accepts bytes, sequences the decision
// cycle, the line emit loop and the rescan of a carried word.
// ----------------------------------------------------------------------------
`default_nettype none

module gww_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gww_pkg::stat_t  stat,
  output gww_pkg::cmd_t   cmd
);
  import gww_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROC,
    S_EMIT,
    S_EMIT_LD,
    S_MARK,
    S_NEXT,
    S_SCAN_LD
  } state_t;

  state_t state;
  state_t state_next;
  state_t after_st;
  logic   reproc;
  logic   reproc_next;

  // Where to go once a line is out: the byte that broke the line is decided
  // again, otherwise the rescan goes on or the block waits for input.
  always_comb begin
    priority if (reproc) begin
      after_st = S_PROC;
    end else if (stat.scanning) begin
      after_st = S_NEXT;
    end else begin
      after_st = S_IDLE;
    end
  end

  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    state_next  = state;
    reproc_next = reproc;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (stat.in_eot) begin
            reproc_next = 1'b0;
            state_next  = S_EMIT;
          end else begin
            state_next = S_PROC;
          end
        end
      end
      S_PROC: begin
        cmd.proc = 1'b1;
        unique case (stat.act)
          ACT_BREAK: begin
            reproc_next = 1'b1;
            state_next  = S_EMIT;
          end
          ACT_NEWLINE, ACT_CARRY, ACT_STORE_CAP: begin
            reproc_next = 1'b0;
            state_next  = S_EMIT;
          end
          default: begin
            reproc_next = 1'b0;
            state_next  = stat.scanning ? S_NEXT : S_IDLE;
          end
        endcase
      end
      S_EMIT: begin
        if (stat.emit_zero) begin
          state_next = stat.emit_mark ? S_MARK : after_st;
        end else begin
          cmd.emit_rd = 1'b1;
          state_next  = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        if (stat.out_free) begin
          cmd.emit_ld = 1'b1;
          state_next  = stat.emit_last ? after_st : S_EMIT;
        end
      end
      S_MARK: begin
        if (stat.out_free) begin
          cmd.mark_ld = 1'b1;
          state_next  = after_st;
        end
      end
      S_NEXT: begin
        if (stat.scan_more) begin
          cmd.scan_rd = 1'b1;
          state_next  = S_SCAN_LD;
        end else begin
          cmd.scan_end = 1'b1;
          state_next   = S_PROC;
        end
      end
      S_SCAN_LD: begin
        cmd.scan_ld = 1'b1;
        state_next  = S_PROC;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      reproc <= 1'b0;
    end else begin
      state  <= state_next;
      reproc <= reproc_next;
    end
  end

  a_idle_no_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !stat.scanning)
    else $error("waiting for input in the middle of a rescan");

  a_emit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_LD) |-> !stat.emit_zero)
    else $error("character read for an empty line");

  a_reproc_no_break: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PROC) && reproc) |-> ((stat.act != ACT_BREAK) && (stat.act != ACT_CARRY)))
    else $error("a byte broke the line twice");

endmodule

`default_nettype wire

[rtl/greedy_word_wrap.sv]
// ----------------------------------------------------------------------------
// greedy_word_wrap: text bytes in, wrapped lines out one character per item.
// A byte that ends no line is accepted, then decided; each emitted character is a line
// memory read, then an output register load; a carried word is read back, loaded and decided byte by byte.
// Reset clears control state, loads 320 / 8 / 64; the line memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_word_wrap #(
  parameter int LINE_BUF = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  gww_pkg::cfg_idx_t              cfg_index,
  input  logic [gww_pkg::CFG_DATA_W-1:0] cfg_data,
  gww_in_if.sink                         text_in,
  gww_out_if.source                      line_out
);
  import gww_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gww_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text_in.valid),
    .in_ready (text_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gww_dp #(
    .LINE_BUF (LINE_BUF)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (text_in.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (line_out.ready),
    .out_valid (line_out.valid),
    .out_data  (line_out.data)
  );

endmodule

`default_nettype wire
